// ===== rtl/life_cell_automaton_stencil_top_assert.svh =====
// Assertion macros for the life stencil block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LIFE_CELL_AUTOMATON_STENCIL_TOP_ASSERT_SVH
`define LIFE_CELL_AUTOMATON_STENCIL_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define LCA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("life stencil: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define LCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("life stencil: next-cycle check failed");
`else
`define LCA_ASSERT_IMPLY(label, ante, cons)
`define LCA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/lca_pkg.sv =====
package lca_pkg;

  // Default grid limits handed to the top level parameters.
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;

  // Size registers.
  localparam int         SIZE_W     = 11;
  localparam int         SIZE_MIN   = 3;
  localparam logic [10:0] SIZE_RESET = 11'd1024;

  // Rule constants.
  localparam logic [7:0] ALIVE_VALUE = 8'hFF;
  localparam logic [3:0] NBR_BIRTH   = 4'd3;
  localparam logic [3:0] NBR_KEEP    = 4'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } lca_cfg_idx_t;

  // Input request payload.
  typedef struct packed {
    logic [7:0] cell_value;
    logic       is_flush;
  } lca_in_t;

  // Result payload.
  typedef struct packed {
    logic [7:0] next_value;
    logic       end_of_row;
    logic       end_of_frame;
    logic       last_of_run;
  } lca_out_t;

endpackage

// ===== rtl/life_cell_automaton_stencil_top.sv =====
// Streaming Game of Life stencil (rule B3/S23) over a grayscale raster.
// Input channel (in_valid/in_ready/in_data): one pixel request per cycle in raster
// order; a pixel is alive only at value 255. After each frame, one row of flush
// requests (grid_width of them) drains the last row.
// Result channel (out_valid/out_ready/out_data): the next generation, one row and
// one column behind the input, with end_of_row, end_of_frame and last_of_run flags.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): grid_width at index 0,
// grid_height at index 1, both clamped to 3..MAX; write while the block is idle.
// A request moves from the read stage registers on into the result register.
// Throughput: one request per cycle while the receiver keeps up. A request that ends
// a row after row 0 causes two results, which share the single result register, so
// the input pauses once per row.
// Line stores are one-port-per-side arrays addressed by the column counter; a fill
// count makes entries never written since reset read as zero, so no clearing pass.
// Reset (rst_n, synchronous) clears counters, window, fill count and the pipeline,
// and sets both sizes to 1024. While the receiver stalls, one request can still be
// taken into the read stage; after that in_ready drops until results drain.
`include "life_cell_automaton_stencil_top_assert.svh"

module life_cell_automaton_stencil_top
  import lca_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  lca_in_t      in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output lca_out_t     out_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  lca_cfg_idx_t cfg_index,
  input  logic [10:0]  cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int FW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int SWW = ((SIZE_W > FW) ? SIZE_W : FW) + 1;
  localparam int SHW = ((SIZE_W > RW) ? SIZE_W : RW) + 1;

  // Neighbor count and rule for a window whose center is bit 4.
  function automatic logic [7:0] life_rule(input logic [8:0] win, input logic [7:0] own);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n = n + 4'(win[i]);
    end
    case (n)
      NBR_BIRTH: life_rule = ALIVE_VALUE;
      NBR_KEEP:  life_rule = own;
      default:   life_rule = 8'd0;
    endcase
  endfunction

  // Configuration registers.
  logic [10:0] grid_width_r, grid_height_r;
  logic        cfg_acc;

  assign cfg_ready = rst_n;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= SIZE_RESET;
      grid_height_r <= SIZE_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping.
  logic [SWW-1:0] w_raw, w_sz;
  logic [SHW-1:0] h_raw, h_sz;

  always_comb begin
    w_raw = SWW'(grid_width_r);
    h_raw = SHW'(grid_height_r);
    if (w_raw < SWW'(SIZE_MIN))       w_sz = SWW'(SIZE_MIN);
    else if (w_raw > SWW'(MAX_WIDTH)) w_sz = SWW'(MAX_WIDTH);
    else                              w_sz = w_raw;
    if (h_raw < SHW'(SIZE_MIN))        h_sz = SHW'(SIZE_MIN);
    else if (h_raw > SHW'(MAX_HEIGHT)) h_sz = SHW'(MAX_HEIGHT);
    else                               h_sz = h_raw;
  end

  // Pipeline control signals.
  logic in_acc, b_go, out_free;
  logic b_vld_r;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = rst_n && (!b_vld_r || b_go);

  // Position decode for the incoming request.
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          row_end, flush_row, in_fresh;
  logic [7:0]    val_in;

  always_comb begin
    row_end   = (SWW'(col_cnt_r) + SWW'(1)) >= w_sz;
    flush_row = SHW'(row_cnt_r) >= h_sz;
    val_in    = (in_data.is_flush || flush_row) ? 8'd0 : in_data.cell_value;
    in_fresh  = FW'(col_cnt_r) >= fill_r;
    if (row_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = flush_row ? '0 : row_cnt_r + RW'(1);
    end else begin
      col_cnt_nxt = col_cnt_r + CW'(1);
      row_cnt_nxt = row_cnt_r;
    end
    fill_nxt = (FW'(col_cnt_r) == fill_r) ? fill_r + FW'(1) : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      fill_r    <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // Read stage registers, loaded on each accepted request.
  logic [CW-1:0] b_col_r;
  logic [7:0]    b_val_r;
  logic          b_fresh_r, b_top_r, b_first_r, b_res1_r, b_res2_r, b_rend_r, b_last_r;
  logic          up_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      up_wr_r <= 1'b0;
    end else begin
      up_wr_r <= in_acc;
      if (in_acc)    b_vld_r <= 1'b1;
      else if (b_go) b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_col_r   <= col_cnt_r;
      b_val_r   <= val_in;
      b_fresh_r <= in_fresh;
      b_top_r   <= row_cnt_r <= RW'(1);
      b_first_r <= col_cnt_r == '0;
      b_res1_r  <= (row_cnt_r != '0) && (col_cnt_r != '0);
      b_res2_r  <= (row_cnt_r != '0) && row_end;
      b_rend_r  <= row_end;
      b_last_r  <= flush_row;
    end
  end

  // Line stores: the middle row is read and rewritten at the accept edge; the
  // upper row gets its new alive bit in the cycle after, once the old middle value is out.
  logic [7:0] mid_mem [MAX_WIDTH];
  logic       up_mem  [MAX_WIDTH];
  logic [7:0] mid_rd_r;
  logic       up_rd_r;
  logic [7:0] mid_b;
  logic       up_b;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_rd_r            <= up_mem[col_cnt_r];
      mid_rd_r           <= mid_mem[col_cnt_r];
      mid_mem[col_cnt_r] <= val_in;
    end
    if (up_wr_r) begin
      up_mem[b_col_r] <= (mid_b == ALIVE_VALUE);
    end
  end

  // Window shift and rule evaluation.
  logic [8:0] win_r, win_base, win_nxt;
  logic [7:0] ctr_r, ctr_base;
  logic [2:0] col_bits;
  lca_out_t   res1, res2;

  always_comb begin
    mid_b    = b_fresh_r ? 8'd0 : mid_rd_r;
    up_b     = (b_fresh_r || b_top_r) ? 1'b0 : up_rd_r;
    win_base = b_first_r ? 9'd0 : win_r;
    ctr_base = b_first_r ? 8'd0 : ctr_r;
    col_bits = {b_val_r == ALIVE_VALUE, mid_b == ALIVE_VALUE, up_b};
    win_nxt  = {win_base[5:0], col_bits};

    res1.next_value   = life_rule(win_nxt, ctr_base);
    res1.end_of_row   = 1'b0;
    res1.end_of_frame = 1'b0;
    res1.last_of_run  = !b_rend_r;

    res2.next_value   = life_rule({win_nxt[5:0], 3'b000}, mid_b);
    res2.end_of_row   = 1'b1;
    res2.end_of_frame = b_last_r;
    res2.last_of_run  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      ctr_r <= '0;
    end else if (b_go) begin
      win_r <= win_nxt;
      ctr_r <= mid_b;
    end
  end

  // Result register with room for the second result of a row end.
  logic     o_vld_r, o_sec_r;
  lca_out_t o_data_r, o_sec_data_r;

  assign out_free  = !o_vld_r || (out_ready && !o_sec_r);
  assign b_go      = b_vld_r && out_free;
  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      o_sec_r <= 1'b0;
    end else if (b_go && (b_res1_r || b_res2_r)) begin
      o_vld_r <= 1'b1;
      o_sec_r <= b_res1_r && b_res2_r;
    end else if (o_vld_r && out_ready) begin
      if (o_sec_r) o_sec_r <= 1'b0;
      else         o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && (b_res1_r || b_res2_r)) begin
      o_data_r     <= b_res1_r ? res1 : res2;
      o_sec_data_r <= res2;
    end else if (o_vld_r && out_ready && o_sec_r) begin
      o_data_r <= o_sec_data_r;
    end
  end

  // A pending second result always sits behind a valid first one.
  `LCA_ASSERT_IMPLY(a_sec_needs_first, o_sec_r, o_vld_r)
  // The column counter never runs ahead of the written part of the line stores.
  `LCA_ASSERT_IMPLY(a_col_within_fill, 1'b1, FW'(col_cnt_r) <= fill_r)
  // A row-end request with two results leaves both in the result register.
  `LCA_ASSERT_NEXT(a_two_results_held, b_go && b_res1_r && b_res2_r, o_vld_r && o_sec_r)

endmodule

// ===== sim/life_cell_automaton_stencil_top_tb.sv =====
`timescale 1ns / 100ps

module life_cell_automaton_stencil_top_tb
  import lca_pkg::*;
();

  localparam int MAX_W = DEFAULT_MAX_WIDTH;
  localparam int MAX_H = DEFAULT_MAX_HEIGHT;
  localparam int unsigned ITEMS_TOTAL = 1050;

  // Tracks the next generation of the grid and holds the result cells still due.
  class next_gen_tracker;
    bit         up_alive [MAX_W];
    bit   [7:0] mid_row [MAX_W];
    bit   [8:0] win_alive;
    bit  [15:0] win_center;
    int unsigned col;
    int unsigned row;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    lca_out_t   due_cells [$];
    int unsigned errors;

    function new();
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      win_alive  = '0;
      win_center = '0;
      col        = 0;
      row        = 0;
      errors     = 0;
    endfunction

    function int unsigned clamp_size(logic [10:0] v, int unsigned hi);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp_size(width_reg, MAX_W);
    endfunction

    function int unsigned eff_height();
      return clamp_size(height_reg, MAX_H);
    endfunction

    // The row counter alone decides where the flush row is.
    function bit in_flush_row();
      return row >= eff_height();
    endfunction

    // Number of requests from the current position up to the end of the flush row.
    function int unsigned items_to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned n;
      w = eff_width();
      h = eff_height();
      n = (col + 1 >= w) ? 1 : w - col;
      if (row < h) n += (h - row) * w;
      return n;
    endfunction

    function void set_reg(lca_cfg_idx_t idx, logic [10:0] data);
      case (idx)
        CFG_GRID_WIDTH: width_reg = data;
        CFG_GRID_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    // B3/S23 on a 3x3 window whose center is bit 4.
    function bit [7:0] rule_value(bit [8:0] win, bit [7:0] own);
      int n;
      n = $countones(win) - win[4];
      if (n == NBR_BIRTH) return ALIVE_VALUE;
      if (n == NBR_KEEP) return own;
      return 8'd0;
    endfunction

    // Advance the line stores and window by one accepted request.
    function void take_pixel(lca_in_t d);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      bit flush_row;
      bit row_end;
      bit up_b;
      bit [7:0] val;
      bit [7:0] mid;
      lca_out_t res;
      w = eff_width();
      h = eff_height();
      c = col;
      r = row;
      flush_row = (r >= h);
      val = (d.is_flush || flush_row) ? 8'd0 : d.cell_value;
      row_end = (c + 1 >= w);

      up_b = up_alive[c];
      mid = mid_row[c];
      up_alive[c] = (mid == ALIVE_VALUE);
      mid_row[c] = val;
      // Rows above the top and columns left of the first one are dead.
      if (r <= 1) up_b = 1'b0;
      if (c == 0) begin
        win_alive = '0;
        win_center = '0;
      end
      win_alive = {win_alive[5:0], val == ALIVE_VALUE, mid == ALIVE_VALUE, up_b};
      win_center = {win_center[7:0], mid};

      if (r >= 1 && c >= 1) begin
        res.next_value = rule_value(win_alive, win_center[15:8]);
        res.end_of_row = 1'b0;
        res.end_of_frame = 1'b0;
        res.last_of_run = !row_end;
        due_cells.push_back(res);
      end
      // The last column of a row sees a dead column to its right.
      if (r >= 1 && row_end) begin
        res.next_value = rule_value({win_alive[5:0], 3'b000}, win_center[7:0]);
        res.end_of_row = 1'b1;
        res.end_of_frame = flush_row;
        res.last_of_run = 1'b1;
        due_cells.push_back(res);
      end

      if (row_end) begin
        col = 0;
        row = flush_row ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void match_result(lca_out_t got);
      lca_out_t want;
      if (due_cells.size() == 0) begin
        $display("%0t: unexpected result: value %0d row_end %0b frame_end %0b last %0b",
                 $time, got.next_value, got.end_of_row, got.end_of_frame, got.last_of_run);
        errors++;
        return;
      end
      want = due_cells.pop_front();
      if (got.next_value !== want.next_value || got.end_of_row !== want.end_of_row ||
          got.end_of_frame !== want.end_of_frame || got.last_of_run !== want.last_of_run) begin
        $display("%0t: mismatch: expected value %0d flags %b%b%b, got value %0d flags %b%b%b",
                 $time, want.next_value, want.end_of_row, want.end_of_frame,
                 want.last_of_run, got.next_value, got.end_of_row, got.end_of_frame,
                 got.last_of_run);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_cells.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  lca_in_t      in_data = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  lca_out_t     out_data;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  lca_cfg_idx_t cfg_index = CFG_GRID_WIDTH;
  logic [10:0]  cfg_data = '0;
  bit           steady = 1'b0;
  int unsigned  items_sent = 0;

  next_gen_tracker next_gen = new();

  life_cell_automaton_stencil_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // The receiver stalls now and then, except during the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  // Every accepted result is checked against the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) next_gen.match_result(out_data);
  end

  // Present one pixel request, with an occasional gap before it.
  task automatic send_cell(lca_in_t d);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    next_gen.take_pixel(d);
    items_sent++;
  endtask

  task automatic write_reg(lca_cfg_idx_t idx, logic [10:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    next_gen.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Let every due result drain, then give a request of row 0 time to clear the pipe.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (next_gen.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly well-formed pixels; a few carry a misplaced flush flag.
  function automatic lca_in_t make_pixel(bit flush_slot);
    lca_in_t d;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    d.is_flush = flush_slot;
    if ($urandom_range(0, 99) < 5) d.is_flush = !flush_slot;
    if (pick < 45) d.cell_value = ALIVE_VALUE;
    else if (pick < 55) d.cell_value = 8'd254;
    else if (pick < 63) d.cell_value = 8'd0;
    else d.cell_value = 8'($urandom_range(0, 255));
    return d;
  endfunction

  task automatic run_items(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_cell(make_pixel(next_gen.in_flush_row()));
  endtask

  // Stimulus.
  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned pick;
    int unsigned spin;
    logic [10:0] size_val;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Smallest grid; height below the minimum saturates to 3.
    write_reg(CFG_GRID_WIDTH, 11'd3);
    write_reg(CFG_GRID_HEIGHT, 11'd2);
    send_cell({8'd254, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd1, 1'b0});
    send_cell({8'd0, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd128, 1'b0});
    send_cell({8'd7, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd0, 1'b1});
    send_cell({8'd255, 1'b1});
    send_cell({8'd0, 1'b1});
    wait_idle();

    // Width below the minimum; a flush flag inside the frame and a pixel in the flush row.
    write_reg(CFG_GRID_WIDTH, 11'd1);
    write_reg(CFG_GRID_HEIGHT, 11'd3);
    send_cell({8'd255, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd254, 1'b0});
    send_cell({8'd255, 1'b1});
    send_cell({8'd1, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd128, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd255, 1'b0});
    send_cell({8'd255, 1'b1});
    send_cell({8'd0, 1'b1});
    wait_idle();

    // Both sizes saturating from the top keep row 0 open past column 40; a small
    // grid then ends that row at once. No stalls on either side in this stretch.
    steady = 1'b1;
    write_reg(CFG_GRID_WIDTH, 11'd2047);
    write_reg(CFG_GRID_HEIGHT, 11'd1100);
    run_items(40);
    wait_idle();
    write_reg(CFG_GRID_WIDTH, 11'd16);
    write_reg(CFG_GRID_HEIGHT, 11'd6);
    run_items(next_gen.items_to_frame_end());
    wait_idle();
    steady = 1'b0;

    // Random sizes; some phases stop mid-frame so the next sizes apply mid-frame.
    while (items_sent < ITEMS_TOTAL) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick != 9) begin
        case ($urandom_range(0, 9))
          0: size_val = 11'($urandom_range(0, 2));
          1: size_val = 11'($urandom_range(13, 40));
          default: size_val = 11'($urandom_range(3, 12));
        endcase
        write_reg(CFG_GRID_WIDTH, size_val);
      end
      if (pick != 8) begin
        case ($urandom_range(0, 9))
          0: size_val = 11'($urandom_range(0, 2));
          1: size_val = 11'($urandom_range(9, 16));
          default: size_val = 11'($urandom_range(3, 8));
        endcase
        write_reg(CFG_GRID_HEIGHT, size_val);
      end
      w = next_gen.eff_width();
      h = next_gen.eff_height();
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2 * w);
      else n = next_gen.items_to_frame_end() + $urandom_range(0, 1) * (h + 1) * w;
      if (n > ITEMS_TOTAL - items_sent) n = ITEMS_TOTAL - items_sent;
      run_items(n);
    end

    // Drain the last results, then allow for anything stray.
    @(negedge clk);
    in_valid <= 1'b0;
    for (spin = 0; spin < 100000 && next_gen.pending() != 0; spin++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (next_gen.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, next_gen.pending());
    end
    if (next_gen.errors == 0 && next_gen.pending() == 0) begin
      $display("[life_cell_automaton_stencil_top] OK");
    end else begin
      $display("[life_cell_automaton_stencil_top] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #6000000;
    $display("[life_cell_automaton_stencil_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lca_pkg.sv
rtl/life_cell_automaton_stencil_top.sv
sim/life_cell_automaton_stencil_top_tb.sv
